// ===== rtl/core/lz77_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lz77_pkg;

    localparam int WINDOW     = 4096;
    localparam int MAX_MATCH  = 15;
    localparam int AW         = $clog2(WINDOW);
    localparam int CW         = AW + 1;
    localparam int OFF_W      = 13;
    localparam int LEN_W      = 4;
    localparam int BYTE_W     = 8;
    localparam int CMD_DEPTH  = 2;
    localparam int CMD_PW     = $clog2(CMD_DEPTH);

    typedef struct packed {
        logic [OFF_W-1:0]  match_offset;
        logic [LEN_W-1:0]  match_length;
        logic [BYTE_W-1:0] literal_byte;
    } in_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
        logic              bad_offset;
    } out_word_t;

    typedef struct packed {
        logic [AW-1:0]     off;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] lit;
        logic              bad;
        logic              fwd;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_COPY,
        BK_LIT
    } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/lz77_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface lz77_in_if;
    logic               valid;
    logic               ready;
    lz77_pkg::in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lz77_out_if;
    logic                valid;
    logic                ready;
    lz77_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lz77_decoder_top.sv =====
// Path: a triple passes through the command queue and the back-end state register, and
// a copy also through the history RAM read register, before its first word is registered
// at the output. Throughput: a triple holds the back end until its copied bytes and its
// literal are written out, one word per cycle while the output is taken; the history RAM
// read port paces the copy loop.
// Reset: rst_n clears pointers, byte counts, queue and output valid; history is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module lz77_decoder_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lz77_in_if.sink    triple,
    lz77_out_if.source decoded
);

    lz77_pkg::cmd_t              push_cmd;
    lz77_pkg::cmd_t              head;
    lz77_pkg::fifo_stat_t        stat;
    logic                        push;
    logic                        pop;
    logic                        ram_we;
    logic [lz77_pkg::AW-1:0]     ram_waddr;
    logic [lz77_pkg::BYTE_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [lz77_pkg::AW-1:0]     ram_raddr;
    logic [lz77_pkg::BYTE_W-1:0] ram_rdata;

    lz77_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .triple (triple),
        .stat   (stat),
        .push   (push),
        .cmd    (push_cmd)
    );

    lz77_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (stat)
    );

    lz77_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!stat.empty),
        .pop        (pop),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .decoded    (decoded)
    );

    lz77_ram #(
        .WIDTH (lz77_pkg::BYTE_W),
        .DEPTH (lz77_pkg::WINDOW)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("command popped from empty queue");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (triple.valid && triple.ready) |=> !stat.empty)
        else $error("accepted triple missing from queue");

    a_bad_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (decoded.valid && !decoded.data.last_of_run) |-> !decoded.data.bad_offset)
        else $error("bad offset flagged on a copied byte");

endmodule

`default_nettype wire

// ===== rtl/core/lz77_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lz77_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lz77_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lz77_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    lz77_in_if.sink                  triple,
    input  wire lz77_pkg::fifo_stat_t stat,
    output logic                     push,
    output lz77_pkg::cmd_t           cmd
);

    logic [lz77_pkg::CW-1:0]    vcnt_reg;
    logic [lz77_pkg::CW-1:0]    vcnt_next;
    logic [lz77_pkg::CW:0]      vsum;
    logic [lz77_pkg::LEN_W-1:0] len_sat;
    logic [lz77_pkg::LEN_W-1:0] len_eff;
    logic                       bad;

    assign triple.ready = !stat.full;
    assign push         = triple.valid && !stat.full;

    always_comb
    begin
        if (32'(triple.data.match_length) > 32'(lz77_pkg::MAX_MATCH))
        begin
            len_sat = lz77_pkg::LEN_W'(lz77_pkg::MAX_MATCH);
        end
        else
        begin
            len_sat = triple.data.match_length;
        end

        bad = (len_sat != '0)
              && ((triple.data.match_offset == '0)
                  || (32'(triple.data.match_offset) > 32'(vcnt_reg)));
        len_eff = bad ? '0 : len_sat;

        cmd.off = triple.data.match_offset[lz77_pkg::AW-1:0];
        cmd.len = len_eff;
        cmd.lit = triple.data.literal_byte;
        cmd.bad = bad;
        cmd.fwd = (triple.data.match_offset == lz77_pkg::OFF_W'(1));

        // count copied bytes plus the literal, saturate at window size
        vsum = {1'b0, vcnt_reg} + (lz77_pkg::CW + 1)'(len_eff) + (lz77_pkg::CW + 1)'(1);
        if (32'(vsum) >= 32'(lz77_pkg::WINDOW))
        begin
            vcnt_next = lz77_pkg::CW'(lz77_pkg::WINDOW);
        end
        else
        begin
            vcnt_next = vsum[lz77_pkg::CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcnt_reg <= '0;
        end
        else if (push)
        begin
            vcnt_reg <= vcnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lz77_cmd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lz77_cmd_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire lz77_pkg::cmd_t       push_cmd,
    input  wire logic                 pop,
    output lz77_pkg::cmd_t            head,
    output lz77_pkg::fifo_stat_t      stat
);

    lz77_pkg::cmd_t              mem_reg [lz77_pkg::CMD_DEPTH];
    logic [lz77_pkg::CMD_PW-1:0] wptr_reg;
    logic [lz77_pkg::CMD_PW-1:0] rptr_reg;
    logic [lz77_pkg::CMD_PW:0]   cnt_reg;
    logic [lz77_pkg::CMD_PW:0]   cnt_next;

    assign head       = mem_reg[rptr_reg];
    assign stat.full  = (cnt_reg == (lz77_pkg::CMD_PW + 1)'(lz77_pkg::CMD_DEPTH));
    assign stat.empty = (cnt_reg == '0);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (32'(wptr_reg) == lz77_pkg::CMD_DEPTH - 1) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (32'(rptr_reg) == lz77_pkg::CMD_DEPTH - 1) ? '0 : rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lz77_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lz77_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire lz77_pkg::cmd_t               head,
    input  wire logic                         head_valid,
    output logic                              pop,
    output logic                              ram_we,
    output logic [lz77_pkg::AW-1:0]           ram_waddr,
    output logic [lz77_pkg::BYTE_W-1:0]       ram_wdata,
    output logic                              ram_re,
    output logic [lz77_pkg::AW-1:0]           ram_raddr,
    input  wire logic [lz77_pkg::BYTE_W-1:0]  ram_rdata,
    lz77_out_if.source                        decoded
);

    lz77_pkg::back_state_t       state_reg;
    lz77_pkg::back_state_t       state_next;
    logic [lz77_pkg::AW-1:0]     wp_reg;
    logic [lz77_pkg::BYTE_W-1:0] last_byte_reg;
    logic                        pend_reg;
    logic [lz77_pkg::LEN_W-1:0]  rd_cnt_reg;
    logic [lz77_pkg::LEN_W-1:0]  emit_cnt_reg;
    logic                        out_valid_reg;
    lz77_pkg::out_word_t         out_word_reg;

    logic                        can_emit;
    logic                        emit_copy;
    logic                        emit_lit;
    logic                        issue;
    logic                        copy_done;
    logic [lz77_pkg::BYTE_W-1:0] copy_byte;
    logic [lz77_pkg::BYTE_W-1:0] emit_byte;

    assign decoded.valid = out_valid_reg;
    assign decoded.data  = out_word_reg;

    always_comb
    begin
        can_emit  = !out_valid_reg || decoded.ready;
        emit_copy = (state_reg == lz77_pkg::BK_COPY) && pend_reg && can_emit;
        emit_lit  = (state_reg == lz77_pkg::BK_LIT) && can_emit;
        issue     = (state_reg == lz77_pkg::BK_COPY) && (rd_cnt_reg < head.len)
                    && (!pend_reg || emit_copy);
        copy_done = emit_copy && ((emit_cnt_reg + 1'b1) == head.len);
        // distance one reads the byte written just before
        copy_byte = head.fwd ? last_byte_reg : ram_rdata;
        emit_byte = emit_lit ? head.lit : copy_byte;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lz77_pkg::BK_IDLE:
            begin
                if (head_valid)
                begin
                    state_next = (head.len != '0) ? lz77_pkg::BK_COPY : lz77_pkg::BK_LIT;
                end
            end
            lz77_pkg::BK_COPY:
            begin
                if (copy_done)
                begin
                    state_next = lz77_pkg::BK_LIT;
                end
            end
            lz77_pkg::BK_LIT:
            begin
                if (emit_lit)
                begin
                    state_next = lz77_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = lz77_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop       = emit_lit;
        ram_we    = emit_copy || emit_lit;
        ram_waddr = wp_reg;
        ram_wdata = emit_byte;
        ram_re    = issue;
        ram_raddr = (emit_copy ? wp_reg + 1'b1 : wp_reg) - head.off;
    end

    always_ff @(posedge clk)
    begin
        if (emit_copy || emit_lit)
        begin
            out_word_reg.out_byte    <= emit_byte;
            out_word_reg.last_of_run <= emit_lit;
            out_word_reg.bad_offset  <= emit_lit && head.bad;
            last_byte_reg            <= emit_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lz77_pkg::BK_IDLE;
            wp_reg        <= '0;
            pend_reg      <= 1'b0;
            rd_cnt_reg    <= '0;
            emit_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_copy || emit_lit)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (state_reg == lz77_pkg::BK_IDLE)
            begin
                rd_cnt_reg   <= '0;
                emit_cnt_reg <= '0;
                pend_reg     <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                end
                if (emit_copy)
                begin
                    emit_cnt_reg <= emit_cnt_reg + 1'b1;
                end
                if (issue)
                begin
                    pend_reg <= 1'b1;
                end
                else if (emit_copy)
                begin
                    pend_reg <= 1'b0;
                end
            end
            if (emit_copy || emit_lit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (decoded.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
